FILE: sv/tbs_pkg.sv
// tbs_pkg: shared types, codes and helper functions for the typed bounded stack.
// Used by every other file of the block but tbs_ram; depends on nothing.
`timescale 1ns / 1ps

package tbs_pkg;

    // Field widths
    localparam int DATA_W   = 64;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 9;
    localparam int TYPE_W   = 4;
    localparam int CAP_W    = 9;

    // Default number of storage entries
    localparam int DEPTH_DEF = 256;

    // Configuration port geometry: two 32-bit registers at byte 0 and 4
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register select, taken from paddr[2]
    localparam logic REG_ELEM_TYPE = 1'b0;
    localparam logic REG_CAPACITY  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Where the read value of a result comes from
    typedef enum logic [1:0] {
        RD_ZERO = 2'd0,
        RD_ONES = 2'd1,
        RD_MEM  = 2'd2
    } t_rd_src;

    // Element type codes
    localparam logic [TYPE_W-1:0] TY_NONE = 4'd0;
    localparam logic [TYPE_W-1:0] TY_U8   = 4'd1;
    localparam logic [TYPE_W-1:0] TY_U16  = 4'd2;
    localparam logic [TYPE_W-1:0] TY_U32  = 4'd3;
    localparam logic [TYPE_W-1:0] TY_U64  = 4'd4;
    localparam logic [TYPE_W-1:0] TY_I8   = 4'd5;
    localparam logic [TYPE_W-1:0] TY_I16  = 4'd6;
    localparam logic [TYPE_W-1:0] TY_I32  = 4'd7;
    localparam logic [TYPE_W-1:0] TY_I64  = 4'd8;
    localparam logic [TYPE_W-1:0] TY_PTR  = 4'd9;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [TYPE_W-1:0] elem_type;
        logic [CAP_W-1:0]  capacity;
    } t_cfg;

    // Largest fill reachable: the capacity register cannot exceed 511
    function automatic int f_max_fill(input int depth);
        f_max_fill = (depth < 511) ? depth : 511;
    endfunction

    // Address bits for a store of the given depth
    function automatic int f_addr_w(input int depth);
        f_addr_w = (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Keep only the bits of the element type; none keeps nothing
    function automatic logic [DATA_W-1:0] f_trunc(input logic [DATA_W-1:0] v,
                                                  input logic [TYPE_W-1:0] t);
        case (t)
            TY_U8, TY_I8:           f_trunc = {56'd0, v[7:0]};
            TY_U16, TY_I16:         f_trunc = {48'd0, v[15:0]};
            TY_U32, TY_I32:         f_trunc = {32'd0, v[31:0]};
            TY_U64, TY_I64, TY_PTR: f_trunc = v;
            default:                f_trunc = '0;
        endcase
    endfunction

    // Zero- or sign-extend a stored entry by the current type
    function automatic logic [DATA_W-1:0] f_extend(input logic [DATA_W-1:0] v,
                                                   input logic [TYPE_W-1:0] t);
        case (t)
            TY_U8:                  f_extend = {56'd0, v[7:0]};
            TY_U16:                 f_extend = {48'd0, v[15:0]};
            TY_U32:                 f_extend = {32'd0, v[31:0]};
            TY_I8:                  f_extend = {{56{v[7]}}, v[7:0]};
            TY_I16:                 f_extend = {{48{v[15]}}, v[15:0]};
            TY_I32:                 f_extend = {{32{v[31]}}, v[31:0]};
            TY_U64, TY_I64, TY_PTR: f_extend = v;
            default:                f_extend = '0;
        endcase
    endfunction

endpackage

FILE: sv/tbs_if.sv
// tbs_if: valid/ready channel interfaces for commands and results.
// Depends on tbs_pkg for field widths.
`timescale 1ns / 1ps

interface tbs_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tbs_pkg::CMD_W-1:0]     cmd;
    logic signed [tbs_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output cmd, output push_value, input ready);
    modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface tbs_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [tbs_pkg::DATA_W-1:0] read_value;
    logic [tbs_pkg::STATUS_W-1:0]      status;
    logic [tbs_pkg::FILL_W-1:0]        fill_count;

    modport source (output valid, output read_value, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input fill_count,
                    output ready);
endinterface

FILE: sv/typed_bounded_stack.sv
// typed_bounded_stack: LIFO stack whose element type and capacity are registers.
// Depends on tbs_pkg, tbs_if, tbs_ram, tbs_cfg and tbs_core.
//
// Usage:
//   i_cmd carries one command per item (push, pop, peek, clear) with a push value;
//   o_rsp returns exactly one result per item: read value, status, fill count.
//   Both are valid/ready channels; an item moves when valid and ready are high.
//   The APB-style port holds elem_type (byte 0) and capacity (byte 4); write
//   them only while no item is in flight.
// Result path: the RAM read is issued at the accepting edge, and the pending
//   stage then the output register carry the result; o_rsp can stall it.
// Throughput: one item per cycle while o_rsp takes results; each command
//   touches at most one RAM entry and the stack pointer, and a read issued
//   for one item lands while the next decodes.
// Reset (synchronous, active low): the stack is empty, type is none and capacity
//   is the full depth. The element RAM is not cleared; only written entries
//   are ever read.
// Stall: while a result waits in the output register one more item is taken
//   and parked on its RAM read; further commands wait until o_rsp drains.
`timescale 1ns / 1ps

module typed_bounded_stack #(
    parameter int DEPTH = tbs_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tbs_cmd_if.sink                     i_cmd,
    tbs_rsp_if.source                   o_rsp,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [tbs_pkg::APB_AW-1:0]  i_paddr,
    input  logic [tbs_pkg::APB_DW-1:0]  i_pwdata,
    output logic [tbs_pkg::APB_DW-1:0]  o_prdata,
    output logic                        o_pready
);
    import tbs_pkg::*;

    localparam int MAX_FILL = f_max_fill(DEPTH);
    localparam int AW       = f_addr_w(MAX_FILL);

    t_cfg              cfg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // Configuration registers
    tbs_cfg #(
        .DEPTH (DEPTH)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // Pointer, decode and result path
    tbs_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Element store
    tbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_FILL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

FILE: sv/tbs_ram.sv
// tbs_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tbs_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tbs_cfg.sv
// tbs_cfg: APB-style configuration registers (element type, capacity).
// Depends on tbs_pkg.
`timescale 1ns / 1ps

module tbs_cfg #(
    parameter int DEPTH = tbs_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [tbs_pkg::APB_AW-1:0]  i_paddr,
    input  logic [tbs_pkg::APB_DW-1:0]  i_pwdata,
    output logic [tbs_pkg::APB_DW-1:0]  o_prdata,
    output logic                        o_pready,
    output tbs_pkg::t_cfg               o_cfg
);
    import tbs_pkg::*;

    localparam int MAX_FILL = f_max_fill(DEPTH);

    logic [TYPE_W-1:0] r_elem_type;
    logic [CAP_W-1:0]  r_capacity;
    logic              wr_en;

    assign wr_en = i_psel && i_penable && i_pwrite;

    // Register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_type <= TY_NONE;
            r_capacity  <= CAP_W'(MAX_FILL);
        end else if (wr_en) begin
            case (i_paddr[2])
                REG_ELEM_TYPE: r_elem_type <= i_pwdata[TYPE_W-1:0];
                REG_CAPACITY:  r_capacity  <= i_pwdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        case (i_paddr[2])
            REG_ELEM_TYPE: o_prdata = APB_DW'(r_elem_type);
            REG_CAPACITY:  o_prdata = APB_DW'(r_capacity);
            default:       o_prdata = '0;
        endcase
    end

    assign o_pready        = 1'b1;
    assign o_cfg.elem_type = r_elem_type;
    assign o_cfg.capacity  = r_capacity;

endmodule

FILE: sv/tbs_core.sv
// tbs_core: stack pointer, command decode, RAM access and result registers.
// Depends on tbs_pkg and tbs_if; drives the element RAM at the top level.
`timescale 1ns / 1ps

module tbs_core #(
    parameter  int DEPTH    = tbs_pkg::DEPTH_DEF,
    localparam int MAX_FILL = tbs_pkg::f_max_fill(DEPTH),
    localparam int AW       = tbs_pkg::f_addr_w(MAX_FILL)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tbs_pkg::t_cfg               i_cfg,
    tbs_cmd_if.sink                     i_cmd,
    tbs_rsp_if.source                   o_rsp,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [tbs_pkg::DATA_W-1:0]  o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [tbs_pkg::DATA_W-1:0]  i_mem_rdata
);
    import tbs_pkg::*;

    localparam int CNT_W = $clog2(MAX_FILL + 1);
    localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_FILL);

    // Fill count
    logic [CNT_W-1:0]    r_count, n_count;
    // Item waiting on the RAM read
    logic                r_pend;
    t_status             r_st, n_st;
    t_rd_src             r_src, n_src;
    logic [FILL_W-1:0]   r_fill;
    // Output register
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_rd_value;
    t_status             r_status;
    logic [FILL_W-1:0]   r_fill_out;

    logic                slot_free, acc, empty, full;
    logic [CAP_W-1:0]    cap_eff;
    logic [DATA_W-1:0]   rd_value;

    assign slot_free   = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = !r_pend || slot_free;
    assign acc         = i_cmd.valid && i_cmd.ready;

    assign cap_eff = (i_cfg.capacity > MAX_CAP) ? MAX_CAP : i_cfg.capacity;
    assign empty   = (r_count == '0);
    assign full    = (CAP_W'(r_count) >= cap_eff);

    // Command decode: pointer update, RAM write or read issue
    always_comb begin
        n_count     = r_count;
        n_st        = ST_OK;
        n_src       = RD_ZERO;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_waddr = r_count[AW-1:0];
        o_mem_raddr = AW'(r_count - 1'b1);
        o_mem_wdata = f_trunc(i_cmd.push_value, i_cfg.elem_type);
        case (t_cmd'(i_cmd.cmd))
            CMD_PUSH: begin
                if (full) begin
                    n_st = ST_FULL;
                end else begin
                    o_mem_we = acc;
                    n_count  = r_count + 1'b1;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (empty) begin
                    n_st  = ST_EMPTY;
                    n_src = RD_ONES;
                end else begin
                    o_mem_re = acc;
                    n_src    = RD_MEM;
                    if (t_cmd'(i_cmd.cmd) == CMD_POP) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                if (empty) begin
                    n_st = ST_EMPTY;
                end
                n_count = '0;
            end
            default: ;
        endcase
    end

    // Pointer and pending stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            if (acc) begin
                r_count <= n_count;
            end
            if (i_cmd.ready) begin
                r_pend <= acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_st   <= n_st;
            r_src  <= n_src;
            r_fill <= FILL_W'(n_count);
        end
    end

    // Read value, extended by the current type
    always_comb begin
        case (r_src)
            RD_ONES: rd_value = '1;
            RD_MEM:  rd_value = f_extend(i_mem_rdata, i_cfg.elem_type);
            default: rd_value = '0;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && slot_free) begin
            r_rd_value <= rd_value;
            r_status   <= r_st;
            r_fill_out <= r_fill;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_rd_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.fill_count = r_fill_out;

endmodule

FILE: test/typed_bounded_stack_tb.sv
// typed_bounded_stack_tb: self-checking bench for the typed bounded stack.
// A directed table, then randomized phases over type and capacity settings.
// Depends on tbs_pkg, tbs_if and typed_bounded_stack.
`timescale 1ns / 1ps

module typed_bounded_stack_tb;
    import tbs_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int NUM_PHASES  = 12;
    localparam int HOLD_PHASE  = 1;    // receiver holds off at the start of this phase
    localparam int PAUSE_PHASE = 6;    // sender waits for all results halfway through
    localparam int LONG_HOLD   = 300;
    localparam int CFG_SETTLE  = 4;    // result latency plus margin
    localparam int TAIL_CYCLES = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 50;

    // Type codes with no defined meaning; the stack treats them as none
    localparam logic [TYPE_W-1:0] TY_UNUSED_LO = 4'd10;
    localparam logic [TYPE_W-1:0] TY_UNUSED_HI = 4'd15;

    localparam logic [DATA_W-1:0] EMPTY_READ = '1;
    localparam logic [DATA_W-1:0] MIN_VALUE  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAX_VALUE  = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic [DATA_W-1:0] rd;
        t_status           st;
        logic [FILL_W-1:0] fill;
    } t_stack_result;

    typedef enum logic [1:0] {
        ROW_CMD,
        ROW_TYPE,
        ROW_CAP
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_cmd              cmd;
        logic [DATA_W-1:0] value;   // push value, or register value for config rows
        logic              fixed;   // expected result typed in below
        t_stack_result     exp;
    } t_dir_row;

    typedef struct {
        logic [TYPE_W-1:0] elem_type;
        logic [CAP_W-1:0]  capacity;
        int                items;
        int                push_w;
        int                pop_w;
        int                peek_w;
        bit                send_idle;
        bit                recv_idle;
    } t_phase;

    localparam int NUM_DIR = 36;

    logic i_clk;
    logic i_rst_n;

    logic              apb_psel;
    logic              apb_penable;
    logic              apb_pwrite;
    logic [APB_AW-1:0] apb_paddr;
    logic [APB_DW-1:0] apb_pwdata;
    logic [APB_DW-1:0] apb_prdata;
    logic              apb_pready;

    tbs_cmd_if cmd_ch ();
    tbs_rsp_if rsp_ch ();

    typed_bounded_stack u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_ch),
        .o_rsp     (rsp_ch),
        .i_psel    (apb_psel),
        .i_penable (apb_penable),
        .i_pwrite  (apb_pwrite),
        .i_paddr   (apb_paddr),
        .i_pwdata  (apb_pwdata),
        .o_prdata  (apb_prdata),
        .o_pready  (apb_pready)
    );

    // Stack contents and register values as the bench believes them
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int                stack_fill;
    logic [TYPE_W-1:0] cfg_type;
    logic [CAP_W-1:0]  cfg_cap;

    t_stack_result pending_results [$];

    t_dir_row dir_rows [NUM_DIR];
    t_phase   phases [NUM_PHASES];

    bit send_idle_on;
    bit recv_idle_on;
    bit drain_hold_req;

    int err_count;
    int cmds_sent;
    int results_seen;
    int full_seen;
    int empty_seen;
    int deepest_fill;
    int cfg_writes;
    int stall_cycles;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic int type_width(input logic [TYPE_W-1:0] t);
        case (t)
            TY_U8, TY_I8:           return 8;
            TY_U16, TY_I16:         return 16;
            TY_U32, TY_I32:         return 32;
            TY_U64, TY_I64, TY_PTR: return 64;
            default:                return 0;
        endcase
    endfunction

    // Cut a value to the type width; optionally sign-extend for signed types
    function automatic logic [DATA_W-1:0] fit_to_type(input logic [DATA_W-1:0] v,
                                                      input logic [TYPE_W-1:0] t,
                                                      input bit sign_ext);
        int                w;
        logic [DATA_W-1:0] mask;
        w = type_width(t);
        if (w == 0) return '0;
        if (w == DATA_W) return v;
        mask = (64'd1 << w) - 64'd1;
        v = v & mask;
        if (sign_ext && (t inside {[TY_I8:TY_I64]}) && v[w-1]) v = v | ~mask;
        return v;
    endfunction

    function automatic t_stack_result predict_stack_result(input t_cmd c,
                                                          input logic [DATA_W-1:0] v);
        t_stack_result r;
        int            limit;
        r.rd = '0;
        r.st = ST_OK;
        limit = (cfg_cap > STACK_DEPTH) ? STACK_DEPTH : int'(cfg_cap);
        case (c)
            CMD_PUSH: begin
                if (stack_fill >= limit) begin
                    r.st = ST_FULL;
                end else begin
                    stack_mem[stack_fill] = fit_to_type(v, cfg_type, 1'b0);
                    stack_fill++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (stack_fill == 0) begin
                    r.st = ST_EMPTY;
                    r.rd = EMPTY_READ;
                end else begin
                    r.rd = fit_to_type(stack_mem[stack_fill-1], cfg_type, 1'b1);
                    if (c == CMD_POP) stack_fill--;
                end
            end
            default: begin
                if (stack_fill == 0) r.st = ST_EMPTY;
                stack_fill = 0;
            end
        endcase
        r.fill = stack_fill[FILL_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_cmd pick_cmd(input t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        if (r < ph.push_w) return CMD_PUSH;
        if (r < ph.push_w + ph.pop_w) return CMD_POP;
        if (r < ph.push_w + ph.pop_w + ph.peek_w) return CMD_PEEK;
        return CMD_CLEAR;
    endfunction

    // Extremes, single bits and low-bit masks mixed with plain random values
    function automatic logic [DATA_W-1:0] pick_push_value();
        case ($urandom_range(0, 9))
            0:       return MIN_VALUE;
            1:       return MAX_VALUE;
            2:       return '1;
            3:       return 64'd1 << $urandom_range(0, DATA_W-1);
            4:       return (64'd1 << $urandom_range(1, DATA_W-1)) - 64'd1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        if (err_count == MAX_REPORTS)
            $display("%0t: further mismatches not shown", $time);
    endtask

    // Offer one command until taken, then record what it should produce
    task automatic issue_command(input t_cmd c, input logic [DATA_W-1:0] v,
                                 input logic fixed, input t_stack_result fixed_res);
        t_stack_result predicted;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd        <= c;
        cmd_ch.push_value <= v;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        predicted = predict_stack_result(c, v);
        pending_results.push_back(fixed ? fixed_res : predicted);
        cmds_sent++;
        if (send_idle_on && $urandom_range(0, 99) < 25) begin
            cmd_ch.valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every result is back
    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Register write on an idle stack, then read back
    task automatic write_config_reg(input logic sel, input logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] mask;
        logic [APB_DW-1:0] rdata;
        wait_results_drained();
        repeat (CFG_SETTLE) @(posedge i_clk);
        mask = (sel == REG_CAPACITY) ? (32'd1 << CAP_W) - 32'd1 : (32'd1 << TYPE_W) - 32'd1;
        if (sel == REG_CAPACITY) cfg_cap = val[CAP_W-1:0];
        else cfg_type = val[TYPE_W-1:0];
        // write: setup then access, upper bits random
        apb_psel    <= 1'b1;
        apb_penable <= 1'b0;
        apb_pwrite  <= 1'b1;
        apb_paddr   <= {sel, 2'b00};
        apb_pwdata  <= ($urandom & ~mask) | (val & mask);
        @(posedge i_clk);
        apb_penable <= 1'b1;
        do @(posedge i_clk); while (apb_pready !== 1'b1);
        // read back the same register
        apb_penable <= 1'b0;
        apb_pwrite  <= 1'b0;
        @(posedge i_clk);
        apb_penable <= 1'b1;
        do @(posedge i_clk); while (apb_pready !== 1'b1);
        rdata = apb_prdata;
        apb_psel    <= 1'b0;
        apb_penable <= 1'b0;
        cfg_writes++;
        if (rdata !== (val & mask))
            report_mismatch(sel == REG_CAPACITY ? "capacity readback" : "elem_type readback",
                            64'(val & mask), 64'(rdata));
    endtask

    // ---------------------------------------------------------------
    // Result side: ready with random stalls, one long hold on request
    // ---------------------------------------------------------------

    initial begin : result_drain
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (drain_hold_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                drain_hold_req = 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 99) < 30) begin
                rsp_ch.ready <= 1'b0;
                repeat (pick_gap()) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_stack_result want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no command pending, read_value", '0,
                                rsp_ch.read_value);
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.read_value !== want.rd)
                    report_mismatch("read_value", want.rd, rsp_ch.read_value);
                if (rsp_ch.status !== want.st)
                    report_mismatch("status", 64'(want.st), 64'(rsp_ch.status));
                if (rsp_ch.fill_count !== want.fill)
                    report_mismatch("fill_count", 64'(want.fill), 64'(rsp_ch.fill_count));
            end
            if (rsp_ch.status == ST_FULL) full_seen++;
            if (rsp_ch.status == ST_EMPTY) empty_seen++;
            if (rsp_ch.fill_count > deepest_fill) deepest_fill = rsp_ch.fill_count;
        end
    end

    // Watchdog: nothing moving on any port for too long
    always @(posedge i_clk) begin : stall_watch
        if (i_rst_n !== 1'b1) begin
            stall_cycles = 0;
        end else if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
                     (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) || apb_psel) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin : main_seq
        int p;
        int i;

        i_rst_n           <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.cmd        <= CMD_PUSH;
        cmd_ch.push_value <= '0;
        apb_psel          <= 1'b0;
        apb_penable       <= 1'b0;
        apb_pwrite        <= 1'b0;
        apb_paddr         <= '0;
        apb_pwdata        <= '0;

        stack_fill     = 0;
        cfg_type       = TY_NONE;
        cfg_cap        = CAP_W'(STACK_DEPTH);
        send_idle_on   = 1'b1;
        recv_idle_on   = 1'b1;
        drain_hold_req = 1'b0;
        err_count      = 0;
        cmds_sent      = 0;
        results_seen   = 0;
        full_seen      = 0;
        empty_seen     = 0;
        deepest_fill   = 0;
        cfg_writes     = 0;

        // kind, cmd, value, fixed, expected {read_value, status, fill}
        dir_rows = '{
            // reset state: type none, empty stack
            '{ROW_CMD,  CMD_POP,   '0,                    1'b1, '{EMPTY_READ, ST_EMPTY, 9'd0}},
            '{ROW_CMD,  CMD_PEEK,  '0,                    1'b1, '{EMPTY_READ, ST_EMPTY, 9'd0}},
            '{ROW_CMD,  CMD_CLEAR, '0,                    1'b1, '{64'd0, ST_EMPTY, 9'd0}},
            '{ROW_CMD,  CMD_PUSH,  MAX_VALUE,             1'b1, '{64'd0, ST_OK, 9'd1}},
            '{ROW_CMD,  CMD_PEEK,  '0,                    1'b1, '{64'd0, ST_OK, 9'd1}},
            '{ROW_CMD,  CMD_POP,   '0,                    1'b1, '{64'd0, ST_OK, 9'd0}},
            // signed byte, then read back as unsigned byte
            '{ROW_TYPE, CMD_PUSH,  64'(TY_I8),            1'b0, '0},
            '{ROW_CMD,  CMD_PUSH,  64'h80,                1'b1, '{64'd0, ST_OK, 9'd1}},
            '{ROW_CMD,  CMD_PUSH,  64'hFFFF_FFFF_FFFF_FF7F, 1'b1, '{64'd0, ST_OK, 9'd2}},
            '{ROW_CMD,  CMD_PEEK,  '0,                    1'b0, '0},
            '{ROW_TYPE, CMD_PUSH,  64'(TY_U8),            1'b0, '0},
            '{ROW_CMD,  CMD_POP,   '0,                    1'b0, '0},
            '{ROW_CMD,  CMD_POP,   '0,                    1'b0, '0},
            // full-width signed minimum
            '{ROW_TYPE, CMD_PUSH,  64'(TY_I64),           1'b0, '0},
            '{ROW_CMD,  CMD_PUSH,  MIN_VALUE,             1'b1, '{64'd0, ST_OK, 9'd1}},
            '{ROW_CMD,  CMD_POP,   '0,                    1'b0, '0},
            // undefined type code behaves as none
            '{ROW_TYPE, CMD_PUSH,  64'(TY_UNUSED_HI),     1'b0, '0},
            '{ROW_CMD,  CMD_PUSH,  '1,                    1'b1, '{64'd0, ST_OK, 9'd1}},
            '{ROW_CMD,  CMD_PEEK,  '0,                    1'b1, '{64'd0, ST_OK, 9'd1}},
            '{ROW_CMD,  CMD_CLEAR, '0,                    1'b1, '{64'd0, ST_OK, 9'd0}},
            // zero capacity refuses every push
            '{ROW_CAP,  CMD_PUSH,  64'd0,                 1'b0, '0},
            '{ROW_CMD,  CMD_PUSH,  '0,                    1'b1, '{64'd0, ST_FULL, 9'd0}},
            // fill to capacity, then lower capacity below the fill
            '{ROW_CAP,  CMD_PUSH,  64'd2,                 1'b0, '0},
            '{ROW_TYPE, CMD_PUSH,  64'(TY_I32),           1'b0, '0},
            '{ROW_CMD,  CMD_PUSH,  64'h0000_0001_8000_0000, 1'b1, '{64'd0, ST_OK, 9'd1}},
            '{ROW_CMD,  CMD_PUSH,  64'h7FFF_FFFF,         1'b1, '{64'd0, ST_OK, 9'd2}},
            '{ROW_CMD,  CMD_PUSH,  MAX_VALUE,             1'b1, '{64'd0, ST_FULL, 9'd2}},
            '{ROW_CAP,  CMD_PUSH,  64'd1,                 1'b0, '0},
            '{ROW_CMD,  CMD_PUSH,  MIN_VALUE,             1'b1, '{64'd0, ST_FULL, 9'd2}},
            '{ROW_CMD,  CMD_POP,   '0,                    1'b0, '0},
            '{ROW_CMD,  CMD_PUSH,  '1,                    1'b1, '{64'd0, ST_FULL, 9'd1}},
            '{ROW_CMD,  CMD_POP,   '0,                    1'b0, '0},
            // capacity register above the depth, pointer type
            '{ROW_CAP,  CMD_PUSH,  64'd511,               1'b0, '0},
            '{ROW_TYPE, CMD_PUSH,  64'(TY_PTR),           1'b0, '0},
            '{ROW_CMD,  CMD_PUSH,  64'h8000_0000_0000_0001, 1'b1, '{64'd0, ST_OK, 9'd1}},
            '{ROW_CMD,  CMD_PEEK,  '0,                    1'b0, '0}
        };

        // type, capacity, items, push/pop/peek weights (clear is the rest), idling
        phases[0]  = '{TY_U8,  9'd256, 150, 90, 5,  5,  1'b1, 1'b1};
        phases[1]  = '{TY_I16, 9'd511, 150, 85, 5,  10, 1'b0, 1'b0};
        phases[2]  = '{TY_I32, 9'd3,   100, 30, 40, 25, 1'b1, 1'b1};
        phases[3]  = '{TY_NONE, 9'd0,  60,  40, 30, 20, 1'b1, 1'b0};
        phases[4]  = '{TY_UNUSED_LO, 9'd2, 80, 40, 30, 20, 1'b0, 1'b1};
        phases[5]  = '{TY_I8,  9'd1,   80,  40, 30, 20, 1'b1, 1'b1};
        phases[6]  = '{TY_U16, 9'd40,  120, 55, 25, 15, 1'b1, 1'b1};
        phases[7]  = '{TY_U32, 9'd257, 120, 60, 20, 15, 1'b0, 1'b0};
        phases[8]  = '{TY_I64, 9'd16,  100, 45, 30, 20, 1'b1, 1'b1};
        phases[9]  = '{TY_PTR, 9'd511, 100, 45, 30, 20, 1'b1, 1'b0};
        phases[10] = '{TY_U64, 9'd256, 120, 50, 25, 20, 1'b0, 1'b1};
        phases[11] = '{TY_I8,  9'd100, 100, 45, 30, 20, 1'b1, 1'b1};
        phases[4].elem_type = TYPE_W'($urandom_range(TY_UNUSED_LO, TY_UNUSED_HI));
        phases[8].capacity  = CAP_W'($urandom_range(4, 64));
        phases[11].capacity = CAP_W'($urandom_range(1, 300));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (i = 0; i < NUM_DIR; i++) begin
            case (dir_rows[i].kind)
                ROW_TYPE: write_config_reg(REG_ELEM_TYPE, dir_rows[i].value[APB_DW-1:0]);
                ROW_CAP:  write_config_reg(REG_CAPACITY, dir_rows[i].value[APB_DW-1:0]);
                default:  issue_command(dir_rows[i].cmd, dir_rows[i].value,
                                        dir_rows[i].fixed, dir_rows[i].exp);
            endcase
        end

        // random phases; the stack keeps its contents across setting changes
        for (p = 0; p < NUM_PHASES; p++) begin
            write_config_reg(REG_ELEM_TYPE, 32'(phases[p].elem_type));
            write_config_reg(REG_CAPACITY, 32'(phases[p].capacity));
            send_idle_on = phases[p].send_idle;
            recv_idle_on = phases[p].recv_idle;
            if (p == HOLD_PHASE) drain_hold_req = 1'b1;
            for (i = 0; i < phases[p].items; i++) begin
                if (p == PAUSE_PHASE && i == phases[p].items / 2) wait_results_drained();
                issue_command(pick_cmd(phases[p]), pick_push_value(), 1'b0, '0);
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands (%0d directed rows) across %0d register writes; %0d results",
                 cmds_sent, NUM_DIR, cfg_writes, results_seen);
        $display("Saw %0d full pushes, %0d empty reads or clears, deepest fill %0d",
                 full_seen, empty_seen, deepest_fill);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
